### rtl/wpwr_pkg.sv
`default_nettype none

package wpwr_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    localparam int EIDX_W = 5;
    localparam int WVAL_W = 16;
    localparam int PCNT_W = 6;
    localparam int RFRC_W = 16;

    localparam int EIDX_LSB = 0;
    localparam int WVAL_LSB = EIDX_LSB + EIDX_W;
    localparam int PCNT_LSB = WVAL_LSB + WVAL_W;
    localparam int RFRC_LSB = PCNT_LSB + PCNT_W;

    localparam logic [IN_USER_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [IN_USER_W-1:0] FUNC_START = 2'd1;
    localparam logic [IN_USER_W-1:0] FUNC_DRAW  = 2'd2;

    localparam int MSTEP_W = 4;
    localparam logic [MSTEP_W-1:0] MSTEP_LAST = 4'd15;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SRCH = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### rtl/wpwr_wtab.sv
`default_nettype none

module wpwr_wtab #(
    parameter int POOL_SIZE   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(POOL_SIZE)-1:0] wr_addr,
    input  wire logic [WEIGHT_BITS-1:0]       wr_data,
    input  wire logic [$clog2(POOL_SIZE)-1:0] rd_addr,
    output logic      [WEIGHT_BITS-1:0]       rd_data,
    output logic      [POOL_SIZE-1:0]         nz
);
    import wpwr_pkg::*;

    logic [WEIGHT_BITS-1:0] mem [POOL_SIZE];
    logic [WEIGHT_BITS-1:0] mem_q_reg;
    logic                   nz_q_reg;
    logic [POOL_SIZE-1:0]   nz_reg;

    // nonzero flags double as valid bits, so unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
        end
        else if (wr_en)
        begin
            nz_reg[wr_addr] <= (wr_data != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_addr];
        nz_q_reg  <= nz_reg[rd_addr];
    end

    assign rd_data = nz_q_reg ? mem_q_reg : '0;
    assign nz      = nz_reg;

endmodule

`default_nettype wire

### rtl/weighted_pick_without_replacement_unit.sv
// channel | dir | signals                      | contents
// s       | in  | s_tvalid s_tready s_tdata    | tuser: func
//         |     | s_tuser                      | tdata: entry_index weight_value
//         |     |                              |        pick_count random_fraction
// m       | out | m_tvalid m_tready m_tdata    | tdata: picked picked_index
//         |     | m_tlast                      | tlast: selection_done
//
// load, start and unused codes go from acceptance straight to the result state
// a draw makes one pass over the weight table for the total, 16 shift-add
// steps for the threshold, and one pass for the search
// all passes share one adder and one registered table read port
// rst_n clears control state at once; no clearing pass is needed
// input is held off until the result register accepts the current result

`default_nettype none

module weighted_pick_without_replacement_unit #(
    parameter int POOL_SIZE   = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // entry_index, weight_value, pick_count, random_fraction, zero pad
    input  wire logic [wpwr_pkg::IN_DATA_W-1:0] s_tdata,
    // func
    input  wire logic [wpwr_pkg::IN_USER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // picked, picked_index, zero pad
    output logic [wpwr_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);
    import wpwr_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);
    localparam int CW = IW + 1;
    localparam int TW = WEIGHT_BITS + IW;
    localparam int AW = TW + 1;
    localparam logic [CW-1:0] CNT_END = CW'(POOL_SIZE);

    state_t state_reg, state_next;

    logic [POOL_SIZE-1:0]   avail_reg, avail_next;
    logic [PCNT_W-1:0]      picks_reg, picks_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          thr_reg, thr_next;
    logic [TW-1:0]          run_reg, run_next;
    logic [RFRC_W-1:0]      r_reg, r_next;
    logic [MSTEP_W-1:0]     mstep_reg, mstep_next;
    logic                   res_picked_reg, res_picked_next;
    logic [IW-1:0]          res_idx_reg, res_idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic [EIDX_W-1:0]        in_eidx;
    logic [WVAL_W-1:0]        in_wval;
    logic [PCNT_W-1:0]        in_pcnt;
    logic [RFRC_W-1:0]        in_rfrc;
    logic [WEIGHT_BITS+WVAL_W-1:0] wval_ext;
    logic [IW+EIDX_W-1:0]     eidx_ext;
    logic [IW+EIDX_W-1:0]     ridx_ext;
    logic                     in_range;
    logic                     accept;

    logic                   wr_en;
    logic [IW-1:0]          rd_addr;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic [POOL_SIZE-1:0]   nz;

    logic                   elig;
    logic [TW-1:0]          w_eff;
    logic [TW-1:0]          add_a, add_b;
    logic [AW-1:0]          add_sum;
    logic                   sel_open;
    logic                   cnt_busy;

    assign in_eidx  = s_tdata[EIDX_LSB +: EIDX_W];
    assign in_wval  = s_tdata[WVAL_LSB +: WVAL_W];
    assign in_pcnt  = s_tdata[PCNT_LSB +: PCNT_W];
    assign in_rfrc  = s_tdata[RFRC_LSB +: RFRC_W];
    assign wval_ext = {{WEIGHT_BITS{1'b0}}, in_wval};
    assign eidx_ext = {{IW{1'b0}}, in_eidx};
    assign ridx_ext = {{EIDX_W{1'b0}}, res_idx_reg};
    assign in_range = (32'(in_eidx) < 32'(POOL_SIZE));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == FUNC_LOAD) && in_range;
    assign rd_addr  = cnt_reg[IW-1:0];
    assign cnt_busy = (cnt_reg != CNT_END);

    wpwr_wtab #(
        .POOL_SIZE   (POOL_SIZE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_wtab (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (eidx_ext[IW-1:0]),
        .wr_data (wval_ext[WEIGHT_BITS-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .nz      (nz)
    );

    assign elig     = rd_vld_reg && avail_reg[rd_idx_reg];
    assign w_eff    = elig ? {{IW{1'b0}}, rd_data} : '0;
    assign sel_open = (picks_reg != '0) && (avail_reg != '0);

    // shared adder: total pass, threshold shift-add, running sum pass
    always_comb
    begin
        add_a = run_reg;
        add_b = w_eff;
        case (state_reg)
            ST_SUM:
            begin
                add_a = total_reg;
                add_b = w_eff;
            end
            ST_MUL:
            begin
                add_a = thr_reg;
                add_b = r_reg[0] ? total_reg : '0;
            end
            default:
            begin
                add_a = run_reg;
                add_b = w_eff;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};

    always_comb
    begin
        state_next      = state_reg;
        avail_next      = avail_reg;
        picks_next      = picks_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        total_next      = total_reg;
        thr_next        = thr_reg;
        run_next        = run_reg;
        r_next          = r_reg;
        mstep_next      = mstep_reg;
        res_picked_next = res_picked_reg;
        res_idx_next    = res_idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_picked_next = 1'b0;
                    res_idx_next    = '0;
                    state_next      = ST_RESP;
                    case (s_tuser)
                        FUNC_START:
                        begin
                            picks_next = in_pcnt;
                            avail_next = nz;
                        end
                        FUNC_DRAW:
                        begin
                            if (sel_open)
                            begin
                                total_next = '0;
                                cnt_next   = '0;
                                r_next     = in_rfrc;
                                state_next = ST_SUM;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SUM:
            begin
                if (cnt_busy)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IW-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    total_next = add_sum[TW-1:0];
                end
                if (!cnt_busy && !rd_vld_reg)
                begin
                    thr_next   = '0;
                    mstep_next = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // floor(r * total / 65536), one bit of r per step
                thr_next   = add_sum[AW-1:1];
                r_next     = r_reg >> 1;
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == MSTEP_LAST)
                begin
                    if (total_reg == '0)
                    begin
                        avail_next = '0;
                        picks_next = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        run_next   = '0;
                        state_next = ST_SRCH;
                    end
                end
            end

            ST_SRCH:
            begin
                if (cnt_busy)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IW-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    run_next = add_sum[TW-1:0];
                end
                if (elig && (add_sum > {1'b0, thr_reg}))
                begin
                    res_picked_next         = 1'b1;
                    res_idx_next            = rd_idx_reg;
                    avail_next[rd_idx_reg]  = 1'b0;
                    picks_next              = picks_reg - 1'b1;
                    rd_vld_next             = 1'b0;
                    state_next              = ST_RESP;
                end
                else if (!cnt_busy && !rd_vld_reg)
                begin
                    avail_next = '0;
                    picks_next = '0;
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_DATA_W - EIDX_W - 1){1'b0}},
                                     ridx_ext[EIDX_W-1:0], res_picked_reg};
                    m_tlast_next  = !sel_open;
                    if (!sel_open)
                    begin
                        avail_next = '0;
                        picks_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            avail_reg    <= '0;
            picks_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            avail_reg    <= avail_next;
            picks_reg    <= picks_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        rd_idx_reg     <= rd_idx_next;
        total_reg      <= total_next;
        thr_reg        <= thr_next;
        run_reg        <= run_next;
        r_reg          <= r_next;
        mstep_reg      <= mstep_next;
        res_picked_reg <= res_picked_next;
        res_idx_reg    <= res_idx_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

### rtl/wpwr_chk.sv
`default_nettype none

module wpwr_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [wpwr_pkg::IN_DATA_W-1:0] s_tdata,
    input wire logic [wpwr_pkg::IN_USER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [wpwr_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import wpwr_pkg::*;

    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // no index without a pick
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[EIDX_W:1] == '0))
        else $error("index reported without a pick");

    // one transaction at a time on the input
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a result never shows up the cycle right after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

endmodule

bind weighted_pick_without_replacement_unit wpwr_chk u_wpwr_chk (.*);

`default_nettype wire

### bench/weighted_pick_without_replacement_unit_tb.sv
`timescale 1ns / 100ps

module weighted_pick_without_replacement_unit_tb;

    import wpwr_pkg::*;

    localparam int POOL_SIZE   = 32;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 100;
    localparam int RANDOM_ITEMS = 450;

    localparam logic [IN_USER_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic       picked;
        logic [4:0] entry;
        logic       done;
    } pick_result_t;

    localparam pick_result_t NOTHING_CLOSED = '{picked: 1'b0, entry: 5'd0, done: 1'b1};
    localparam pick_result_t FROM_PREDICTOR = '{picked: 1'b0, entry: 5'd0, done: 1'b0};

    typedef struct {
        logic [IN_USER_W-1:0] func;
        logic [EIDX_W-1:0]    entry;
        logic [WVAL_W-1:0]    weight;
        logic [PCNT_W-1:0]    count;
        logic [RFRC_W-1:0]    frac;
        bit                   typed;
        pick_result_t         want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // entry_index, weight_value, pick_count, random_fraction, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // func
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // picked, picked_index, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    logic [WVAL_W-1:0]    weight_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] live_mask;
    logic [PCNT_W-1:0]    picks_left;

    pick_result_t pending_picks [$];
    stim_row_t    directed_rows [$];
    int           errors;
    int           items_sent;
    int           cycles;
    bit           no_idle;

    weighted_pick_without_replacement_unit #(
        .POOL_SIZE   (POOL_SIZE),
        .WEIGHT_BITS (16)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic bit selection_open();
        return (picks_left != '0) && (live_mask != '0);
    endfunction

    function automatic void close_selection();
        live_mask  = '0;
        picks_left = '0;
    endfunction

    function automatic pick_result_t predict_pick(
        input logic [IN_USER_W-1:0] func,
        input logic [EIDX_W-1:0]    entry,
        input logic [WVAL_W-1:0]    weight,
        input logic [PCNT_W-1:0]    count,
        input logic [RFRC_W-1:0]    frac
    );
        pick_result_t res;
        logic [20:0]  total;
        logic [20:0]  running;
        logic [36:0]  product;
        logic [20:0]  threshold;
        int           chosen;
        res     = '0;
        total   = '0;
        running = '0;
        chosen  = -1;
        case (func)
            FUNC_LOAD: weight_mem[entry] = weight;
            FUNC_START:
            begin
                picks_left = count;
                for (int i = 0; i < POOL_SIZE; i++)
                    live_mask[i] = weight_mem[i] != '0;
                if (!selection_open())
                    close_selection();
            end
            FUNC_DRAW:
            begin
                if (selection_open())
                begin
                    for (int i = 0; i < POOL_SIZE; i++)
                        if (live_mask[i])
                            total += weight_mem[i];
                    product   = frac * total;
                    threshold = product[36:16];
                    for (int i = 0; i < POOL_SIZE; i++)
                    begin
                        if (chosen < 0 && live_mask[i])
                        begin
                            running += weight_mem[i];
                            if (running > threshold)
                                chosen = i;
                        end
                    end
                    if (chosen < 0)
                        close_selection();
                    else
                    begin
                        res.picked        = 1'b1;
                        res.entry         = chosen[4:0];
                        live_mask[chosen] = 1'b0;
                        picks_left        = picks_left - 1'b1;
                        if (!selection_open())
                            close_selection();
                    end
                end
                else
                    close_selection();
            end
            default: ;
        endcase
        res.done = !selection_open();
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WVAL_W-1:0] rand_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return 16'hFFFF;
        else if (roll == 2)
            return WVAL_W'($urandom_range(1, 15));
        return WVAL_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [RFRC_W-1:0] rand_frac();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return 16'hFFFF;
        return RFRC_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic add_row(
        input logic [IN_USER_W-1:0] func,
        input logic [EIDX_W-1:0]    entry,
        input logic [WVAL_W-1:0]    weight,
        input logic [PCNT_W-1:0]    count,
        input logic [RFRC_W-1:0]    frac,
        input bit                   typed,
        input pick_result_t         want
    );
        stim_row_t row;
        row.func   = func;
        row.entry  = entry;
        row.weight = weight;
        row.count  = count;
        row.frac   = frac;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(
        input logic [IN_USER_W-1:0] func,
        input logic [EIDX_W-1:0]    entry,
        input logic [WVAL_W-1:0]    weight,
        input logic [PCNT_W-1:0]    count,
        input logic [RFRC_W-1:0]    frac,
        input bit                   typed,
        input pick_result_t         want
    );
        int           gap;
        pick_result_t predicted;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'b0, frac, count, weight, entry};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_pick(func, entry, weight, count, frac);
        pending_picks.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_random(input logic [IN_USER_W-1:0] func, input logic [PCNT_W-1:0] count);
        send_item(func, EIDX_W'($urandom_range(0, 31)), rand_weight(), count, rand_frac(), 1'b0,
                  FROM_PREDICTOR);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[weighted_pick_without_replacement_unit] ERROR");
        $finish;
    end

    // receiver: random stalls plus one long hold-off to back up the input
    initial
    begin
        bit held;
        int stall;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && items_sent >= 120)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = idle_len();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(30, 80)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_result
        pick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got tdata=%h tlast=%b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (m_tdata[0] !== want.picked)
                begin
                    $display("%0t: picked expected %b, got %b", $time, want.picked, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[5:1] !== want.entry)
                begin
                    $display("%0t: picked_index expected %0d, got %0d",
                             $time, want.entry, m_tdata[5:1]);
                    errors++;
                end
                if (m_tlast !== want.done)
                begin
                    $display("%0t: selection_done expected %b, got %b", $time, want.done, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int n_loads;
        int n_draws;
        int start_count;
        int random_sent;
        errors     = 0;
        items_sent = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            weight_mem[i] = '0;
        close_selection();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_LOAD;

        // after reset nothing is open
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h0000, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_UNUSED, 5'd31, 16'hFFFF, 6'd63, 16'hFFFF, 1'b1, NOTHING_CLOSED);
        // start with all weights zero, then load weights
        add_row(FUNC_START,  5'd0,  16'h0000, 6'd5,  16'h0000, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_LOAD,   5'd0,  16'hFFFF, 6'd0,  16'h0000, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_LOAD,   5'd31, 16'hFFFF, 6'd32, 16'hFFFF, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_LOAD,   5'd21, 16'hAAAA, 6'd0,  16'h5555, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_LOAD,   5'd10, 16'h5555, 6'd0,  16'hAAAA, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_LOAD,   5'd5,  16'h0001, 6'd0,  16'h0000, 1'b1, NOTHING_CLOSED);
        // zero pick count
        add_row(FUNC_START,  5'd0,  16'h0000, 6'd0,  16'h0000, 1'b1, NOTHING_CLOSED);
        add_row(FUNC_START,  5'd0,  16'h0000, 6'd32, 16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_UNUSED, 5'd0,  16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'hFFFF, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h8000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h1234, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'hFFFF, 1'b0, FROM_PREDICTOR);
        // draw on a closed selection
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h4000, 1'b1, NOTHING_CLOSED);
        // count used up after one pick
        add_row(FUNC_START,  5'd0,  16'h0000, 6'd1,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h4000, 1'b0, FROM_PREDICTOR);
        // weights cleared after the start leave a zero total
        add_row(FUNC_START,  5'd0,  16'h0000, 6'd3,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_LOAD,   5'd0,  16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_LOAD,   5'd31, 16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_LOAD,   5'd21, 16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_LOAD,   5'd10, 16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_LOAD,   5'd5,  16'h0000, 6'd0,  16'h0000, 1'b0, FROM_PREDICTOR);
        add_row(FUNC_DRAW,   5'd0,  16'h0000, 6'd0,  16'h8000, 1'b0, FROM_PREDICTOR);

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].func, directed_rows[i].entry, directed_rows[i].weight,
                      directed_rows[i].count, directed_rows[i].frac, directed_rows[i].typed,
                      directed_rows[i].want);

        // well-formed selections with random content, some noise mixed in
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            n_loads = $urandom_range(1, 6);
            repeat (n_loads)
                send_random(FUNC_LOAD, PCNT_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 9) == 0)
                start_count = $urandom_range(0, 32);
            else
                start_count = $urandom_range(1, 8);
            send_random(FUNC_START, PCNT_W'(start_count));
            n_draws = $urandom_range(1, 10);
            repeat (n_draws)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_random(IN_USER_W'($urandom_range(0, 3)),
                                PCNT_W'($urandom_range(0, 63)));
                else
                    send_random(FUNC_DRAW, PCNT_W'($urandom_range(0, 63)));
            end
            random_sent += n_loads + 1 + n_draws;
        end
        s_tvalid <= 1'b0;

        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("[weighted_pick_without_replacement_unit] OK");
        else
            $display("[weighted_pick_without_replacement_unit] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/wpwr_pkg.sv
rtl/wpwr_wtab.sv
rtl/weighted_pick_without_replacement_unit.sv
rtl/wpwr_chk.sv
bench/weighted_pick_without_replacement_unit_tb.sv
